[src/circle_segment_collision_top_macros.svh]
// ----------------------------------------------------------------------------
// Circle segment collision assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SEGMENT_COLLISION_TOP_MACROS_SVH
`define CIRCLE_SEGMENT_COLLISION_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define CSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csc: implication check failed");

// Check a consequent a fixed number of cycles after its antecedent
`define CSC_ASSERT_AFTER(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
		else $error("csc: latency check failed");

`endif

[src/csc_pkg.sv]
// ----------------------------------------------------------------------------
// Circle segment collision package
// Widths, stage counts and types shared by the pipeline modules.
// ----------------------------------------------------------------------------
package csc_pkg;
	// Coordinate format is fixed at 24 bits; all internal scales follow from it
	localparam int CW  = 24;          // coordinate width
	localparam int RW  = CW - 1;      // radius width
	localparam int DW  = CW + 1;      // coordinate difference width
	localparam int SQW = 2 * DW;      // square / dot product width
	localparam int TB  = 62 - CW;     // fraction bits of segment parameter t
	localparam int UB  = 60 - CW;     // fraction bits of unit vector
	localparam int XW  = 62;          // normalized squared distance width
	localparam int LW  = XW / 2;      // square root width
	localparam int KW  = 5;           // normalize shift count width
	localparam int UW  = UB + 1;      // unit component quotient width
	localparam int GW  = CW + 3;      // radius minus distance width

	// Stage counts of each pipeline section
	localparam int PROJ_LAT = 3 + TB + 2;
	localparam int NORM_LAT = 5 + LW;
	localparam int PUSH_LAT = 1 + UW + 3;
	localparam int LAT      = PROJ_LAT + NORM_LAT + PUSH_LAT;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [RW-1:0]        rad_t;
	typedef logic signed [DW-1:0] diff_t;

	// Projection result handed to the distance section
	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t px;
		coord_t py;
		rad_t   r;
	} proj_t;

	// Distance result handed to the push section
	typedef struct packed {
		logic            hit;
		logic            qz;
		coord_t          px;
		coord_t          py;
		diff_t           vx;
		diff_t           vy;
		rad_t            r;
		logic [LW-1:0]   lq;
		logic [KW-1:0]   k;
	} norm_t;
endpackage

[src/csc_proj.sv]
// ----------------------------------------------------------------------------
// Circle segment collision: projection section
// Projects the center onto the segment, clamps t to [0,1] through a
// bit-per-stage divider and forms the closest point.
// ----------------------------------------------------------------------------
module csc_proj import csc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  coord_t sx,
	input  coord_t sy,
	input  coord_t ex,
	input  coord_t ey,
	input  coord_t cx,
	input  coord_t cy,
	input  rad_t   r,
	output logic   out_valid,
	output proj_t  out_data
);
	localparam int NW  = SQW + 1;
	localparam int TW  = TB + 1;
	localparam int TLO = TW / 2;
	localparam int THI = TW - TLO;
	localparam int MLW = DW + TLO + 1;
	localparam int MHW = DW + THI + 1;
	localparam int SW  = DW + TW + 1;

	localparam logic [1:0] T_DIV  = 2'd0;
	localparam logic [1:0] T_ZERO = 2'd1;
	localparam logic [1:0] T_ONE  = 2'd2;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t cx;
		coord_t cy;
		rad_t   r;
		diff_t  dx;
		diff_t  dy;
	} side_t;

	// Stage 1: differences
	logic  v_s1;
	side_t sd_s1;
	diff_t ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sd_s1.sx <= sx;
		sd_s1.sy <= sy;
		sd_s1.cx <= cx;
		sd_s1.cy <= cy;
		sd_s1.r  <= r;
		sd_s1.dx <= DW'(ex) - DW'(sx);
		sd_s1.dy <= DW'(ey) - DW'(sy);
		ax_s1    <= DW'(cx) - DW'(sx);
		ay_s1    <= DW'(cy) - DW'(sy);
	end

	// Stage 2: dot product terms
	logic                  v_s2;
	side_t                 sd_s2;
	logic signed [SQW-1:0] pxa_s2, pya_s2;
	logic [SQW-1:0]        pxx_s2, pyy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sd_s2  <= sd_s1;
		pxa_s2 <= SQW'(sd_s1.dx) * SQW'(ax_s1);
		pya_s2 <= SQW'(sd_s1.dy) * SQW'(ay_s1);
		pxx_s2 <= $unsigned(SQW'(sd_s1.dx) * SQW'(sd_s1.dx));
		pyy_s2 <= $unsigned(SQW'(sd_s1.dy) * SQW'(sd_s1.dy));
	end

	// Stage 3: num, den and clamp decision; divider chain index 0
	// (divider index j is pipeline stage 3 + j)
	logic                 v_s[0:TB];
	side_t                sd_s[0:TB];
	logic [1:0]           mode_s[0:TB];
	logic [SQW-1:0]       den_s[0:TB];
	logic [SQW-1:0]       rem_s[0:TB];
	logic [TB-1:0]        q_s[0:TB];
	logic signed [NW-1:0] num_c;
	logic [SQW-1:0]       den_c;
	logic [1:0]           mode_c;

	always_comb begin
		num_c = NW'(pxa_s2) + NW'(pya_s2);
		den_c = SQW'(pxx_s2 + pyy_s2);
		if (den_c == '0 || num_c <= 0) begin
			mode_c = T_ZERO;
		end else if ($unsigned(num_c) >= NW'(den_c)) begin
			mode_c = T_ONE;
		end else begin
			mode_c = T_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sd_s[0]   <= sd_s2;
		mode_s[0] <= mode_c;
		den_s[0]  <= den_c;
		rem_s[0]  <= num_c[SQW-1:0];
		q_s[0]    <= '0;
	end

	// Restoring divider: one quotient bit of t per stage
	for (genvar j = 0; j < TB; j++) begin : g_tdiv
		logic [SQW:0] sh;
		logic         ge;

		assign sh = {rem_s[j], 1'b0};
		assign ge = sh >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sd_s[j+1]   <= sd_s[j];
			mode_s[j+1] <= mode_s[j];
			den_s[j+1]  <= den_s[j];
			rem_s[j+1]  <= ge ? SQW'(sh - {1'b0, den_s[j]}) : SQW'(sh);
			q_s[j+1]    <= {q_s[j][TB-2:0], ge};
		end
	end

	// Stage 42: select t and form partial products of D*t
	logic [TW-1:0]         t_c;
	logic                  v_s42;
	side_t                 sd_s42;
	logic signed [MLW-1:0] mlx_s42, mly_s42;
	logic signed [MHW-1:0] mhx_s42, mhy_s42;

	always_comb begin
		case (mode_s[TB])
			T_ZERO:  t_c = '0;
			T_ONE:   t_c = TW'(1) << TB;
			default: t_c = {1'b0, q_s[TB]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s42 <= 1'b0;
		end else begin
			v_s42 <= v_s[TB];
		end
	end

	always_ff @(posedge clk) begin
		sd_s42  <= sd_s[TB];
		mlx_s42 <= MLW'(sd_s[TB].dx) * MLW'($signed({1'b0, t_c[TLO-1:0]}));
		mly_s42 <= MLW'(sd_s[TB].dy) * MLW'($signed({1'b0, t_c[TLO-1:0]}));
		mhx_s42 <= MHW'(sd_s[TB].dx) * MHW'($signed({1'b0, t_c[TW-1:TLO]}));
		mhy_s42 <= MHW'(sd_s[TB].dy) * MHW'($signed({1'b0, t_c[TW-1:TLO]}));
	end

	// Stage 43: sum partials, round to nearest and add the start point
	logic signed [SW-1:0] sumx_c, sumy_c, rndx_c, rndy_c;
	logic                 v_s43;
	proj_t                pd_s43;

	always_comb begin
		sumx_c = (SW'(mhx_s42) <<< TLO) + SW'(mlx_s42);
		sumy_c = (SW'(mhy_s42) <<< TLO) + SW'(mly_s42);
		rndx_c = (sumx_c + (SW'(1) <<< (TB - 1))) >>> TB;
		rndy_c = (sumy_c + (SW'(1) <<< (TB - 1))) >>> TB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s43 <= 1'b0;
		end else begin
			v_s43 <= v_s42;
		end
	end

	always_ff @(posedge clk) begin
		pd_s43.cx <= sd_s42.cx;
		pd_s43.cy <= sd_s42.cy;
		pd_s43.r  <= sd_s42.r;
		pd_s43.px <= CW'(SW'(sd_s42.sx) + rndx_c);
		pd_s43.py <= CW'(SW'(sd_s42.sy) + rndy_c);
	end

	assign out_valid = v_s43;
	assign out_data  = pd_s43;
endmodule

[src/csc_norm.sv]
// ----------------------------------------------------------------------------
// Circle segment collision: distance section
// Forms the center offset, the hit test, the normalized squared distance
// and its square root, one root bit per stage.
// ----------------------------------------------------------------------------
module csc_norm import csc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  proj_t in_data,
	output logic  out_valid,
	output norm_t out_data
);
	localparam int R2W = 2 * RW;

	// Stage 1: offset from closest point to center
	logic  v_s1;
	proj_t pd_s1;
	diff_t vx_s1, vy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pd_s1 <= in_data;
		vx_s1 <= DW'(in_data.cx) - DW'(in_data.px);
		vy_s1 <= DW'(in_data.cy) - DW'(in_data.py);
	end

	// Stage 2: squares
	logic           v_s2;
	proj_t          pd_s2;
	diff_t          vx_s2, vy_s2;
	logic [SQW-1:0] sqx_s2, sqy_s2;
	logic [R2W-1:0] r2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pd_s2  <= pd_s1;
		vx_s2  <= vx_s1;
		vy_s2  <= vy_s1;
		sqx_s2 <= $unsigned(SQW'(vx_s1) * SQW'(vx_s1));
		sqy_s2 <= $unsigned(SQW'(vy_s1) * SQW'(vy_s1));
		r2_s2  <= R2W'(pd_s1.r) * R2W'(pd_s1.r);
	end

	// Stage 3: squared distance, hit compare, zero flag
	logic           v_s3;
	norm_t          sb_s3;
	logic [XW-1:0]  x_s3;
	logic [SQW-1:0] q_c;

	assign q_c = SQW'(sqx_s2 + sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sb_s3.hit <= q_c < SQW'(r2_s2);
		sb_s3.qz  <= q_c == '0;
		sb_s3.px  <= pd_s2.px;
		sb_s3.py  <= pd_s2.py;
		sb_s3.vx  <= vx_s2;
		sb_s3.vy  <= vy_s2;
		sb_s3.r   <= pd_s2.r;
		sb_s3.lq  <= '0;
		sb_s3.k   <= '0;
		x_s3      <= XW'(q_c);
	end

	// Stage 4: normalize by 4^16 and 4^8
	logic          v_s4;
	norm_t         sb_s4;
	norm_t         sba_c;
	logic [XW-1:0] xa_c, x_s4;
	logic [KW-1:0] ka_c;

	always_comb begin
		xa_c = x_s3;
		ka_c = '0;
		if (xa_c < (XW'(1) << (XW - 32))) begin
			xa_c    = xa_c << 32;
			ka_c[4] = 1'b1;
		end
		if (xa_c < (XW'(1) << (XW - 16))) begin
			xa_c    = xa_c << 16;
			ka_c[3] = 1'b1;
		end
		sba_c   = sb_s3;
		sba_c.k = ka_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sb_s4 <= sba_c;
		x_s4  <= xa_c;
	end

	// Stage 5: normalize by 4^4, 4^2, 4^1; root chain index 0
	// (root index j is pipeline stage 5 + j)
	logic          v_s[0:LW];
	norm_t         sb_s[0:LW];
	logic [XW-1:0] rd_s[0:LW];
	logic [LW-1:0] rt_s[0:LW];
	logic [XW-1:0] xb_c;
	logic [KW-1:0] kb_c;
	norm_t         sbb_c;

	always_comb begin
		xb_c = x_s4;
		kb_c = sb_s4.k;
		if (xb_c < (XW'(1) << (XW - 8))) begin
			xb_c    = xb_c << 8;
			kb_c[2] = 1'b1;
		end
		if (xb_c < (XW'(1) << (XW - 4))) begin
			xb_c    = xb_c << 4;
			kb_c[1] = 1'b1;
		end
		if (xb_c < (XW'(1) << (XW - 2))) begin
			xb_c    = xb_c << 2;
			kb_c[0] = 1'b1;
		end
		sbb_c   = sb_s4;
		sbb_c.k = kb_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sb_s[0] <= sbb_c;
		rd_s[0] <= xb_c;
		rt_s[0] <= '0;
	end

	// Digit-by-digit square root: one root bit per stage, MSB first
	for (genvar j = 0; j < LW; j++) begin : g_sqrt
		localparam int B = LW - 1 - j;
		logic [XW:0] trial;
		logic        ge;

		assign trial = ((XW + 1)'(rt_s[j]) << (B + 1)) + ((XW + 1)'(1) << (2 * B));
		assign ge    = {1'b0, rd_s[j]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sb_s[j+1] <= sb_s[j];
			rd_s[j+1] <= ge ? XW'({1'b0, rd_s[j]} - trial) : rd_s[j];
			rt_s[j+1] <= ge ? (rt_s[j] | (LW'(1) << B)) : rt_s[j];
		end
	end

	always_comb begin
		out_data    = sb_s[LW];
		out_data.lq = rt_s[LW];
	end

	assign out_valid = v_s[LW];
endmodule

[src/csc_push.sv]
// ----------------------------------------------------------------------------
// Circle segment collision: push section
// Rescales the distance, divides each offset by the root for the unit
// vector, scales by radius minus distance, rounds and saturates.
// ----------------------------------------------------------------------------
module csc_push import csc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  norm_t  in_data,
	output logic   out_valid,
	output logic   hit,
	output coord_t px,
	output coord_t py,
	output coord_t pushx,
	output coord_t pushy
);
	localparam int NXW = LW + 1;
	localparam int SHW = DW + LW;
	localparam int ULO = UW / 2;
	localparam int UHI = UW - ULO;
	localparam int MLW = GW + ULO + 1;
	localparam int MHW = GW + UHI + 1;
	localparam int SW  = 64;

	typedef struct packed {
		logic                  hit;
		logic                  qz;
		logic                  negx;
		logic                  negy;
		coord_t                px;
		coord_t                py;
		logic signed [GW-1:0]  g;
		logic [LW-1:0]         lq;
	} pside_t;

	// Stage 1: rounded distance, gap to radius, scaled offset magnitudes
	// (divider index j is pipeline stage 1 + j)
	logic [LW-1:0]        lc_c;
	logic [DW-1:0]        absx_c, absy_c;
	logic [SHW-1:0]       shx_c, shy_c;
	logic                 v_s[0:UW];
	pside_t               ps_s[0:UW];
	logic [NXW-1:0]       rx_s[0:UW], ry_s[0:UW];
	logic [UW-1:0]        ux_s[0:UW], uy_s[0:UW];

	always_comb begin
		if (in_data.k == '0) begin
			lc_c = in_data.lq;
		end else begin
			lc_c = LW'(({1'b0, in_data.lq >> (in_data.k - KW'(1))} + NXW'(1)) >> 1);
		end
		absx_c = in_data.vx < 0 ? $unsigned(-in_data.vx) : $unsigned(in_data.vx);
		absy_c = in_data.vy < 0 ? $unsigned(-in_data.vy) : $unsigned(in_data.vy);
		shx_c  = SHW'(absx_c) << in_data.k;
		shy_c  = SHW'(absy_c) << in_data.k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ps_s[0].hit  <= in_data.hit;
		ps_s[0].qz   <= in_data.qz;
		ps_s[0].negx <= in_data.vx < 0;
		ps_s[0].negy <= in_data.vy < 0;
		ps_s[0].px   <= in_data.px;
		ps_s[0].py   <= in_data.py;
		ps_s[0].g    <= $signed(GW'(in_data.r)) - $signed(GW'(lc_c));
		ps_s[0].lq   <= in_data.lq;
		rx_s[0]      <= shx_c[NXW-1:0];
		ry_s[0]      <= shy_c[NXW-1:0];
		ux_s[0]      <= '0;
		uy_s[0]      <= '0;
	end

	// Restoring dividers, both axes: integer bit first, then fraction bits
	for (genvar j = 0; j < UW; j++) begin : g_udiv
		logic [NXW-1:0] shx, shy;
		logic           gex, gey;

		if (j == 0) begin : g_first
			assign shx = rx_s[j];
			assign shy = ry_s[j];
		end else begin : g_next
			assign shx = {rx_s[j][NXW-2:0], 1'b0};
			assign shy = {ry_s[j][NXW-2:0], 1'b0};
		end

		assign gex = shx >= NXW'(ps_s[j].lq);
		assign gey = shy >= NXW'(ps_s[j].lq);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			ps_s[j+1] <= ps_s[j];
			rx_s[j+1] <= gex ? shx - NXW'(ps_s[j].lq) : shx;
			ry_s[j+1] <= gey ? shy - NXW'(ps_s[j].lq) : shy;
			ux_s[j+1] <= {ux_s[j][UW-2:0], gex};
			uy_s[j+1] <= {uy_s[j][UW-2:0], gey};
		end
	end

	// Stage 39: partial products of unit component and gap
	logic                  v_s39;
	pside_t                ps_s39;
	logic signed [MLW-1:0] mlx_s39, mly_s39;
	logic signed [MHW-1:0] mhx_s39, mhy_s39;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s39 <= 1'b0;
		end else begin
			v_s39 <= v_s[UW];
		end
	end

	always_ff @(posedge clk) begin
		ps_s39  <= ps_s[UW];
		mlx_s39 <= MLW'(ps_s[UW].g) * MLW'($signed({1'b0, ux_s[UW][ULO-1:0]}));
		mly_s39 <= MLW'(ps_s[UW].g) * MLW'($signed({1'b0, uy_s[UW][ULO-1:0]}));
		mhx_s39 <= MHW'(ps_s[UW].g) * MHW'($signed({1'b0, ux_s[UW][UW-1:ULO]}));
		mhy_s39 <= MHW'(ps_s[UW].g) * MHW'($signed({1'b0, uy_s[UW][UW-1:ULO]}));
	end

	// Stage 40: sum partials and apply the offset sign
	logic                 v_s40;
	pside_t               ps_s40;
	logic signed [SW-1:0] sumx_c, sumy_c, prx_s40, pry_s40;

	assign sumx_c = (SW'(mhx_s39) <<< ULO) + SW'(mlx_s39);
	assign sumy_c = (SW'(mhy_s39) <<< ULO) + SW'(mly_s39);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s40 <= 1'b0;
		end else begin
			v_s40 <= v_s39;
		end
	end

	always_ff @(posedge clk) begin
		ps_s40  <= ps_s39;
		prx_s40 <= ps_s39.negx ? -sumx_c : sumx_c;
		pry_s40 <= ps_s39.negy ? -sumy_c : sumy_c;
	end

	// Stage 41: round, saturate, drop push on zero distance
	localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] CMIN = -(SW'(64'sd1 <<< (CW - 1)));

	logic signed [SW-1:0] rndx_c, rndy_c;
	coord_t               satx_c, saty_c;
	logic                 v_s41, hit_s41;
	coord_t               px_s41, py_s41, pushx_s41, pushy_s41;

	always_comb begin
		rndx_c = (prx_s40 + (SW'(1) <<< (UB - 1))) >>> UB;
		rndy_c = (pry_s40 + (SW'(1) <<< (UB - 1))) >>> UB;
		if (rndx_c > CMAX) begin
			satx_c = CW'(CMAX);
		end else if (rndx_c < CMIN) begin
			satx_c = CW'(CMIN);
		end else begin
			satx_c = CW'(rndx_c);
		end
		if (rndy_c > CMAX) begin
			saty_c = CW'(CMAX);
		end else if (rndy_c < CMIN) begin
			saty_c = CW'(CMIN);
		end else begin
			saty_c = CW'(rndy_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s41 <= 1'b0;
		end else begin
			v_s41 <= v_s40;
		end
	end

	always_ff @(posedge clk) begin
		hit_s41   <= ps_s40.hit;
		px_s41    <= ps_s40.px;
		py_s41    <= ps_s40.py;
		pushx_s41 <= ps_s40.qz ? '0 : satx_c;
		pushy_s41 <= ps_s40.qz ? '0 : saty_c;
	end

	assign out_valid = v_s41;
	assign hit       = hit_s41;
	assign px        = px_s41;
	assign py        = py_s41;
	assign pushx     = pushx_s41;
	assign pushy     = pushy_s41;
endmodule

[src/circle_segment_collision_top.sv]
// ----------------------------------------------------------------------------
// Circle segment collision top level
// Closest point on a segment to a circle center, hit test and push-out
// vector, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         seg_start_x/y, seg_end_x/y, circle_x/y, radius
//  result    done (one cycle)     hit, closest_x/y, push_x/y
//
//  One transaction enters per clock while busy is low.
//  The pipeline holds the bit-per-stage dividers for t (38) and for the unit
//  vector (37) and the bit-per-stage square root (31), plus 14 other stages.
//  busy is high only during reset and the cycle after it.
//  The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "circle_segment_collision_top_macros.svh"

module circle_segment_collision_top import csc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  coord_t seg_start_x,
	input  coord_t seg_start_y,
	input  coord_t seg_end_x,
	input  coord_t seg_end_y,
	input  coord_t circle_x,
	input  coord_t circle_y,
	input  rad_t   radius,
	output logic   done,
	output logic   hit,
	output coord_t closest_x,
	output coord_t closest_y,
	output coord_t push_x,
	output coord_t push_y
);
	logic  busy_q;
	logic  accept;
	logic  prj_valid, nrm_valid;
	proj_t prj_data;
	norm_t nrm_data;

	// Hold off transactions until reset has been released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	csc_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.sx        (seg_start_x),
		.sy        (seg_start_y),
		.ex        (seg_end_x),
		.ey        (seg_end_y),
		.cx        (circle_x),
		.cy        (circle_y),
		.r         (radius),
		.out_valid (prj_valid),
		.out_data  (prj_data)
	);

	csc_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prj_valid),
		.in_data   (prj_data),
		.out_valid (nrm_valid),
		.out_data  (nrm_data)
	);

	csc_push u_push (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nrm_valid),
		.in_data   (nrm_data),
		.out_valid (done),
		.hit       (hit),
		.px        (closest_x),
		.py        (closest_y),
		.pushx     (push_x),
		.pushy     (push_y)
	);

	// Every accepted transaction yields a result at the fixed latency
	`CSC_ASSERT_AFTER(a_lat_result, accept, LAT, done)
	// No result without an accepted transaction at the fixed latency
	`CSC_ASSERT_IMP(a_no_phantom, done, $past(accept, LAT))
	// A nonzero distance always normalizes to a root with its top bit set
	`CSC_ASSERT_IMP(a_root_norm, nrm_valid && !nrm_data.qz, nrm_data.lq[LW-1])
endmodule

[test/csc_checker.sv]
// ----------------------------------------------------------------------------
// Circle segment collision checker
// Watches the command and result channels, predicts each result from the
// accepted command and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module csc_checker import csc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   busy,
	input  coord_t seg_start_x,
	input  coord_t seg_start_y,
	input  coord_t seg_end_x,
	input  coord_t seg_end_y,
	input  coord_t circle_x,
	input  coord_t circle_y,
	input  rad_t   radius,
	input  logic   done,
	input  logic   hit,
	input  coord_t closest_x,
	input  coord_t closest_y,
	input  coord_t push_x,
	input  coord_t push_y,
	output int     mismatches,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic   hit;
		coord_t cx;
		coord_t cy;
		coord_t px;
		coord_t py;
	} contact_t;

	localparam longint CMAXV = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint CMINV = -(64'sd1 <<< (CW - 1));

	contact_t expected_contacts[$];

	// round to nearest, ties toward plus infinity
	function automatic longint round_shr(longint v, int s);
		if (s <= 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > CMAXV)
			return CMAXV;
		if (v < CMINV)
			return CMINV;
		return v;
	endfunction

	// wide product rounding, then clamp to the coordinate range
	function automatic longint round_shr128(logic signed [127:0] v, int s);
		logic signed [127:0] w;
		w = (v + (128'sd1 <<< (s - 1))) >>> s;
		if (w > CMAXV)
			return CMAXV;
		if (w < CMINV)
			return CMINV;
		return longint'(w);
	endfunction

	function automatic contact_t predict_contact(coord_t sxi, coord_t syi, coord_t exi,
			coord_t eyi, coord_t cxi, coord_t cyi, rad_t ri);
		longint sx, sy, ex, ey, cx, cy, r, dx, dy, ax, ay, num, px, py, vx, vy, lc, g;
		longint us;
		longint unsigned den, t, q, lq, n, u;
		int k;
		contact_t c;
		sx = sxi; sy = syi; ex = exi; ey = eyi; cx = cxi; cy = cyi;
		r = longint'({1'b0, ri});
		dx = ex - sx; dy = ey - sy;
		ax = cx - sx; ay = cy - sy;
		num = dx * ax + dy * ay;
		den = dx * dx + dy * dy;
		t = 0;
		if (den != 0 && num > 0) begin
			if (longint'(num) >= longint'(den))
				t = 64'd1 << TB;
			else
				t = 64'((128'(num) << TB) / den);
		end
		px = sx + round_shr(dx * longint'(t), TB);
		py = sy + round_shr(dy * longint'(t), TB);
		vx = cx - px; vy = cy - py;
		c = '0;
		c.px = px[CW-1:0];
		c.py = py[CW-1:0];
		if ((vx < 0 ? -vx : vx) < r && (vy < 0 ? -vy : vy) < r)
			c.hit = longint'(vx * vx + vy * vy) < r * r;
		q = vx * vx + vy * vy;
		if (q != 0) begin
			k = 0;
			while (k < 30 && q < (64'd1 << (60 - 2 * k)))
				k++;
			lq = int_sqrt(q << (2 * k));
			lc = round_shr(longint'(lq), k);
			g = r - lc;
			for (int a = 0; a < 2; a++) begin
				longint comp;
				comp = (a == 0) ? vx : vy;
				n = longint'(comp < 0 ? -comp : comp) << k;
				u = 64'((128'(n) << UB) / lq);
				us = comp < 0 ? -longint'(u) : longint'(u);
				if (a == 0)
					c.cx = coord_t'(clamp_coord(round_shr128(128'(us) * 128'(g), UB)));
				else
					c.cy = coord_t'(clamp_coord(round_shr128(128'(us) * 128'(g), UB)));
			end
		end
		return c;
	endfunction

	// predict on each accepted command, compare on each result strobe
	always @(posedge clk or negedge arst_n) begin
		contact_t e;
		if (!arst_n) begin
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (start && !busy)
				expected_contacts.push_back(predict_contact(seg_start_x, seg_start_y,
					seg_end_x, seg_end_y, circle_x, circle_y, radius));
			if (done) begin
				if (expected_contacts.size() == 0) begin
					if (mismatches < 10)
						$display("%t: result with no command outstanding", $realtime);
					mismatches <= mismatches + 1;
				end else begin
					e = expected_contacts.pop_front();
					if (e.hit !== hit || e.px !== closest_x || e.py !== closest_y ||
							e.cx !== push_x || e.cy !== push_y) begin
						if (mismatches < 10)
							$display({"%t: exp hit=%0d p=(%0d,%0d) push=(%0d,%0d)",
								" got hit=%0d p=(%0d,%0d) push=(%0d,%0d)"},
								$realtime, e.hit, e.px, e.py, e.cx, e.cy,
								hit, closest_x, closest_y, push_x, push_y);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= expected_contacts.size();
		end
	end
endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Circle segment collision testbench
// Drives directed and random segment/circle queries with random idle bursts;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb import csc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_RANDOM = 630;
	localparam int CYCLE_LIMIT = 200000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy, done, hit;
	coord_t seg_start_x = '0, seg_start_y = '0, seg_end_x = '0, seg_end_y = '0;
	coord_t circle_x = '0, circle_y = '0;
	rad_t   radius = '0;
	coord_t closest_x, closest_y, push_x, push_y;
	int     mismatches, pending;
	int     cycles = 0;

	always #6 clk = ~clk;

	circle_segment_collision_top DUT (.*);
	csc_checker u_checker (.*);

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic coord_t CMIN_C();
		return {1'b1, {(CW-1){1'b0}}};
	endfunction

	function automatic coord_t CMAX_C();
		return {1'b0, {(CW-1){1'b1}}};
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
			default: return coord_t'($urandom_range(0, 200000)) - coord_t'(100000);
		endcase
	endfunction

	// hold one command until accepted, then optionally idle
	task automatic send_query(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			coord_t cx, coord_t cy, rad_t r, bit idle);
		int gap;
		seg_start_x <= sx; seg_start_y <= sy;
		seg_end_x <= ex; seg_end_y <= ey;
		circle_x <= cx; circle_y <= cy;
		radius <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int mode;
		coord_t sx, sy;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, degenerate segment, zero distance, zero radius, saturation
		send_query(0, 0, 0, 0, 0, 0, 0, 0);
		send_query(0, 0, 0, 0, 256, 0, 512, 0);
		send_query(0, 0, 1000, 0, 500, 0, 100, 0);
		send_query(0, 0, 1000, 0, 500, 300, 400, 0);
		send_query(0, 0, 1000, 0, -500, 10, 600, 0);
		send_query(0, 0, 1000, 0, 1500, -10, 600, 0);
		send_query(0, 0, 1000, 0, 500, 300, 300, 0);
		send_query(CMIN_C(), CMIN_C(), CMAX_C(), CMAX_C(), CMAX_C(), CMIN_C(), '1, 0);
		send_query(CMAX_C(), CMAX_C(), CMIN_C(), CMIN_C(), CMIN_C(), CMAX_C(), '1, 0);
		send_query(CMIN_C(), CMAX_C(), CMIN_C(), CMAX_C(), CMAX_C(), CMIN_C(), 0, 0);
		send_query(CMAX_C(), 0, CMIN_C(), 0, 0, CMAX_C(), '1, 0);
		send_query(-1, -1, 1, 1, 1, -1, 1, 0);
		send_query(0, 0, 7, 3, 2, 5, 3, 0);
		send_query('1, '1, 0, 0, 5, 5, '1, 0);
		send_query(100, 100, 100, 100, 100, 100, 50, 0);
		send_query(0, 0, 3, 0, 1, 1, 2, 0);

		// random queries; idle bursts stop for the final stretch
		for (int i = 0; i < NUM_RANDOM; i++) begin
			mode = $urandom_range(0, 2);
			sx = rand_coord(mode);
			sy = rand_coord(mode);
			if ($urandom_range(0, 15) == 0)
				send_query(sx, sy, sx, sy, rand_coord(mode), rand_coord(mode),
					rad_t'($urandom), i < NUM_RANDOM - 80);
			else
				send_query(sx, sy, rand_coord(mode), rand_coord(mode), rand_coord(mode),
					rand_coord(mode), (mode == 0) ? rad_t'($urandom) :
					rad_t'($urandom_range(0, 150000)), i < NUM_RANDOM - 80);
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[sim.f]
+incdir+src
src/csc_pkg.sv
src/csc_proj.sv
src/csc_norm.sv
src/csc_push.sv
src/circle_segment_collision_top.sv
test/csc_checker.sv
test/tb.sv
